// ----- src/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
//
// Holds the phase codes, the configuration register indexes and reset values,
// the configuration and result structures, and the width-to-distance scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   // Phase codes of the measurement sequencer.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRIG = 2'd1;
   localparam logic [1:0] PH_MEAS = 2'd2;
   localparam logic [1:0] PH_WAIT = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_PERIODIC_ENABLE = 3'd0;
   localparam logic [2:0] REG_TRIGGER_TICKS   = 3'd1;
   localparam logic [2:0] REG_TIMEOUT_TICKS   = 3'd2;
   localparam logic [2:0] REG_PERIOD_TICKS    = 3'd3;
   localparam logic [2:0] REG_DISTANCE_SCALE  = 3'd4;

   // Field widths.
   localparam int TRIG_W   = 8;
   localparam int TMO_W    = 20;
   localparam int PERIOD_W = 24;
   localparam int SCALE_W  = 16;
   localparam int WIDTH_W  = 20;
   localparam int DIST_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // Register reset values.
   localparam logic                RST_PERIODIC_ENABLE = 1'b0;
   localparam logic [TRIG_W-1:0]   RST_TRIGGER_TICKS   = 8'd10;
   localparam logic [TMO_W-1:0]    RST_TIMEOUT_TICKS   = 20'd30000;
   localparam logic [PERIOD_W-1:0] RST_PERIOD_TICKS    = 24'd60000;
   localparam logic [SCALE_W-1:0]  RST_DISTANCE_SCALE  = 16'd11239;

   localparam logic [WIDTH_W-1:0]  WIDTH_MAX = {WIDTH_W{1'b1}};
   localparam logic [PERIOD_W-1:0] COUNT_MAX = {PERIOD_W{1'b1}};

   typedef struct packed {
      logic                periodic_enable;
      logic [TRIG_W-1:0]   trigger_ticks;
      logic [TMO_W-1:0]    timeout_ticks;
      logic [PERIOD_W-1:0] period_ticks;
      logic [SCALE_W-1:0]  distance_scale;
   } cfg_type;

   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              reading_done;
      logic              reading_valid;
      logic [DIST_W-1:0] distance_mm;
   } res_type;

   // Distance in millimetres: width * scale in Q16, saturated to 16 bits.
   function automatic logic [DIST_W-1:0] scale_width(
      input logic [WIDTH_W-1:0] width,
      input logic [SCALE_W-1:0] scale
   );
      logic [WIDTH_W+SCALE_W-1:0] prod;
      begin
         prod = {{SCALE_W{1'b0}}, width} * {{WIDTH_W{1'b0}}, scale};
         if (|prod[WIDTH_W+SCALE_W-1:DIST_W+SCALE_W]) begin
            scale_width = {DIST_W{1'b1}};
         end else begin
            scale_width = prod[DIST_W+SCALE_W-1:SCALE_W];
         end
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger/echo ultrasonic distance measurement
//
// Top level with the request and response streams, the register port and the
// response output register.
// ----------------------------------------------------------------------------
// Each request transaction is one tick carrying the sampled echo level and a
// start flag; each yields exactly one response transaction. The block takes
// one transaction per clock unless a held response stalls it; its response
// is in the output register the cycle after acceptance. The sequencer state
// and the 20 x 16 distance multiply sit in one stage between the request port
// and that register, and a new request is taken in the same cycle the held
// response leaves. There is no start-up clearing pass. Registers may be
// written at any time the stream is quiet and take effect on the next tick.
`default_nettype none

module ultrasonic_echo_ranger
   import uer_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [0] echo_level, [1] start_request
   // Response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [0] trigger_level, [1] busy_res,
                                                  // [2] reading_done, [3] reading_valid,
                                                  // [19:4] distance_mm
   // Register write port
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type                cfg_ff;
   res_type                res;
   logic                   step;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.periodic_enable <= RST_PERIODIC_ENABLE;
         cfg_ff.trigger_ticks   <= RST_TRIGGER_TICKS;
         cfg_ff.timeout_ticks   <= RST_TIMEOUT_TICKS;
         cfg_ff.period_ticks    <= RST_PERIOD_TICKS;
         cfg_ff.distance_scale  <= RST_DISTANCE_SCALE;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PERIODIC_ENABLE: cfg_ff.periodic_enable <= csr_data[0];
            REG_TRIGGER_TICKS:   cfg_ff.trigger_ticks   <= csr_data[TRIG_W-1:0];
            REG_TIMEOUT_TICKS:   cfg_ff.timeout_ticks   <= csr_data[TMO_W-1:0];
            REG_PERIOD_TICKS:    cfg_ff.period_ticks    <= csr_data[PERIOD_W-1:0];
            REG_DISTANCE_SCALE:  cfg_ff.distance_scale  <= csr_data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Accept a transaction whenever the output register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   uer_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .echo_level    (req_tdata[0]),
      .start_request (req_tdata[1]),
      .cfg           (cfg_ff),
      .res           (res)
   );

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {{(RSP_DATA_W-DIST_W-4){1'b0}}, res.distance_mm, res.reading_valid,
                         res.reading_done, res.busy_res, res.trigger_level};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A finished reading leaves the block neither triggering nor busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> (!rsp_data_ff[1] && !rsp_data_ff[0]))
      else $error("reading_done reported while still busy or triggering");

   // A trigger tick always leaves the block busy.
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> rsp_data_ff[1])
      else $error("trigger_level high without busy_res");

   // A held response blocks new requests.
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while response held");

   // No response right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule

`default_nettype wire

// ----- src/uer_core.sv -----
// ----------------------------------------------------------------------------
// uer_core: trigger and echo measurement sequencer
//
// Holds the phase state and the echo width count, advances them by one tick
// for each accepted transaction and presents that tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_core
   import uer_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire logic    echo_level,
   input  wire logic    start_request,
   input  wire cfg_type cfg,
   output res_type      res
);

   logic [1:0]          phase_ff, phase_in;
   logic [PERIOD_W-1:0] count_ff, count_in;
   logic                echo_prev_ff, echo_prev_in;
   logic                saw_rise_ff, saw_rise_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic                latest_valid_ff, latest_valid_in;
   logic [DIST_W-1:0]   latest_dist_ff, latest_dist_in;

   logic [PERIOD_W-1:0] trig_len;
   logic                trig;
   logic                done;
   logic                complete;

   // A zero trigger length behaves as one tick.
   assign trig_len = (cfg.trigger_ticks == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1}
                                              : {{(PERIOD_W-TRIG_W){1'b0}}, cfg.trigger_ticks};

   // One tick of the sequencer.
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      saw_rise_in     = saw_rise_ff;
      width_in        = width_ff;
      latest_valid_in = latest_valid_ff;
      latest_dist_in  = latest_dist_ff;
      trig            = 1'b0;
      done            = 1'b0;
      complete        = 1'b0;

      // Waiting between periodic measurements.
      if (phase_in == PH_WAIT) begin
         if (!cfg.periodic_enable) begin
            phase_in = PH_IDLE;
         end else if (count_in == '0) begin
            phase_in = PH_TRIG;
            count_in = trig_len;
         end else begin
            count_in = count_in - 1'b1;
         end
      end

      // Start on request or in periodic mode.
      if (phase_in == PH_IDLE && (start_request || cfg.periodic_enable)) begin
         phase_in = PH_TRIG;
         count_in = trig_len;
      end

      if (phase_in == PH_TRIG) begin
         // Drive the trigger pulse; the last pulse tick moves on to measuring.
         trig = 1'b1;
         if (count_in <= {{(PERIOD_W-1){1'b0}}, 1'b1}) begin
            count_in    = '0;
            phase_in    = PH_MEAS;
            saw_rise_in = 1'b0;
            width_in    = '0;
         end else begin
            count_in = count_in - 1'b1;
         end
      end else if (phase_in == PH_MEAS) begin
         if (count_in != COUNT_MAX) begin
            count_in = count_in + 1'b1;
         end
         // A rising edge (re)starts the width count; a fall after it ends it.
         if (echo_level && !echo_prev_ff) begin
            saw_rise_in = 1'b1;
            width_in    = '0;
         end else if (saw_rise_in) begin
            if (width_in != WIDTH_MAX) begin
               width_in = width_in + 1'b1;
            end
            complete = !echo_level && echo_prev_ff;
         end
         if (complete) begin
            done            = 1'b1;
            latest_valid_in = 1'b1;
            latest_dist_in  = scale_width(width_in, cfg.distance_scale);
         end else if (count_in >= {{(PERIOD_W-TMO_W){1'b0}}, cfg.timeout_ticks}) begin
            done            = 1'b1;
            latest_valid_in = 1'b0;
         end
         if (done) begin
            saw_rise_in = 1'b0;
            if (cfg.periodic_enable) begin
               phase_in = PH_WAIT;
               count_in = cfg.period_ticks;
            end else begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         end
      end

      echo_prev_in = echo_level;
   end

   // State update on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         count_ff        <= '0;
         echo_prev_ff    <= 1'b0;
         saw_rise_ff     <= 1'b0;
         width_ff        <= '0;
         latest_valid_ff <= 1'b0;
         latest_dist_ff  <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         echo_prev_ff    <= echo_prev_in;
         saw_rise_ff     <= saw_rise_in;
         width_ff        <= width_in;
         latest_valid_ff <= latest_valid_in;
         latest_dist_ff  <= latest_dist_in;
      end
   end

   // Result of this tick.
   always_comb begin
      res.trigger_level = trig;
      res.busy_res      = (phase_in == PH_TRIG) || (phase_in == PH_MEAS);
      res.reading_done  = done;
      res.reading_valid = latest_valid_in;
      res.distance_mm   = latest_dist_in;
   end

endmodule

`default_nettype wire
